>>> hdl/jsld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jsld_pkg;

   // Scanner phases.
   typedef enum logic [1:0] {
      PH_SEEK,
      PH_BODY,
      PH_ESC,
      PH_HEX
   } phase_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_DATA,
      ST_CLOSED,
      ST_NOOPEN,
      ST_UNTERM,
      ST_BADESC,
      ST_BADHEX,
      ST_SHORTU
   } status_type;

   // Character codes the scanner looks for.
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_LOW_B = 8'h62;
   localparam logic [7:0] CH_LOW_F = 8'h66;
   localparam logic [7:0] CH_LOW_N = 8'h6E;
   localparam logic [7:0] CH_LOW_R = 8'h72;
   localparam logic [7:0] CH_LOW_T = 8'h74;
   localparam logic [7:0] CH_LOW_U = 8'h75;

   // Control characters produced by the short escapes.
   localparam logic [7:0] CC_BS = 8'h08;
   localparam logic [7:0] CC_FF = 8'h0C;

   // UTF-8 encoding constants.
   localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
   localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
   localparam logic [7:0]  UTF_CONT  = 8'h80;
   localparam logic [15:0] UTF_LIM1  = 16'h0080;
   localparam logic [15:0] UTF_LIM2  = 16'h0800;

   // Most results one input byte can cause.
   localparam int unsigned MAX_RESULTS = 4;

   // Depth of the queue between front and back.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_WIDTH  = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      status_type status;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] out_byte;
      status_type status;
   } result_type;

   // All results of one input byte, in order, with their count (1 to 4).
   typedef struct packed {
      result_type [MAX_RESULTS-1:0] slot;
      logic [2:0]                   count;
   } cmd_type;

   // Queue status seen by the front and back parts.
   typedef struct packed {
      logic head_valid;
      logic full;
   } qstat_type;

endpackage

`default_nettype wire

>>> hdl/jsld_front.sv
`timescale 1ns / 1ps
`default_nettype none

module jsld_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire jsld_pkg::req_type req_data,
   input  wire jsld_pkg::qstat_type qstat,
   output logic                   push,
   output jsld_pkg::cmd_type      push_cmd
);

   jsld_pkg::phase_type phase_ff, phase_in;
   logic [15:0] code_ff, code_in;
   logic [1:0]  cnt_ff, cnt_in;

   logic [7:0]  c;
   logic        eoi;
   logic        accept;
   logic        hv_ok;
   logic [3:0]  hv;
   logic [15:0] code_shift;
   logic        is_ws;
   logic [1:0]  pn;
   logic        open;

   function automatic jsld_pkg::result_type mk(input logic [7:0] b,
                                               input jsld_pkg::status_type s);
      jsld_pkg::result_type r;
      r.out_byte = b;
      r.status   = s;
      return r;
   endfunction

   assign c   = req_data.in_byte;
   assign eoi = req_data.end_of_input;

   assign req_ready = !qstat.full;
   assign accept    = req_valid && req_ready;
   assign push      = accept && (push_cmd.count != 3'd0);

   always_comb begin
      hv_ok = 1'b1;
      hv    = 4'h0;
      if (c >= 8'h30 && c <= 8'h39) begin
         hv = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         hv = c[3:0] + 4'd9;
      end else begin
         hv_ok = 1'b0;
      end
   end

   assign code_shift = {code_ff[11:0], hv};
   assign is_ws = (c == jsld_pkg::CH_SPACE) || (c == jsld_pkg::CH_TAB) ||
                  (c == jsld_pkg::CH_CR) || (c == jsld_pkg::CH_LF);

   // Next state.
   always_comb begin
      phase_in = phase_ff;
      code_in  = code_ff;
      cnt_in   = cnt_ff;
      unique case (phase_ff)
         jsld_pkg::PH_BODY: begin
            if (c == jsld_pkg::CH_QUOTE) begin
               phase_in = jsld_pkg::PH_SEEK;
            end else if (c == jsld_pkg::CH_BSL && !eoi) begin
               phase_in = jsld_pkg::PH_ESC;
            end
         end
         jsld_pkg::PH_ESC: begin
            phase_in = jsld_pkg::PH_BODY;
            unique case (c)
               jsld_pkg::CH_QUOTE, jsld_pkg::CH_BSL, jsld_pkg::CH_SLASH,
               jsld_pkg::CH_LOW_B, jsld_pkg::CH_LOW_F, jsld_pkg::CH_LOW_N,
               jsld_pkg::CH_LOW_R, jsld_pkg::CH_LOW_T: begin
                  phase_in = jsld_pkg::PH_BODY;
               end
               jsld_pkg::CH_LOW_U: begin
                  if (!eoi) begin
                     phase_in = jsld_pkg::PH_HEX;
                     code_in  = 16'h0000;
                     cnt_in   = 2'd0;
                  end
               end
               default: begin
                  phase_in = jsld_pkg::PH_SEEK;
               end
            endcase
         end
         jsld_pkg::PH_HEX: begin
            if (!hv_ok) begin
               phase_in = jsld_pkg::PH_SEEK;
            end else begin
               code_in = code_shift;
               cnt_in  = cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  phase_in = jsld_pkg::PH_BODY;
               end
            end
         end
         jsld_pkg::PH_SEEK: begin
            if (c == jsld_pkg::CH_QUOTE) begin
               phase_in = jsld_pkg::PH_BODY;
            end
         end
      endcase
      if (eoi) begin
         phase_in = jsld_pkg::PH_SEEK;
         code_in  = 16'h0000;
         cnt_in   = 2'd0;
      end
   end

   // Results of the current byte.
   always_comb begin
      push_cmd = '0;
      pn       = 2'd0;
      open     = 1'b0;
      unique case (phase_ff)
         jsld_pkg::PH_BODY: begin
            if (c == jsld_pkg::CH_QUOTE) begin
               push_cmd.slot[0] = mk(8'h00, jsld_pkg::ST_CLOSED);
               pn = 2'd1;
            end else if (c == jsld_pkg::CH_BSL && !eoi) begin
               open = 1'b1;
            end else begin
               push_cmd.slot[0] = mk(c, jsld_pkg::ST_DATA);
               pn   = 2'd1;
               open = 1'b1;
            end
         end
         jsld_pkg::PH_ESC: begin
            open = 1'b1;
            pn   = 2'd1;
            unique case (c)
               jsld_pkg::CH_QUOTE, jsld_pkg::CH_BSL, jsld_pkg::CH_SLASH: begin
                  push_cmd.slot[0] = mk(c, jsld_pkg::ST_DATA);
               end
               jsld_pkg::CH_LOW_B: push_cmd.slot[0] = mk(jsld_pkg::CC_BS, jsld_pkg::ST_DATA);
               jsld_pkg::CH_LOW_F: push_cmd.slot[0] = mk(jsld_pkg::CC_FF, jsld_pkg::ST_DATA);
               jsld_pkg::CH_LOW_N: push_cmd.slot[0] = mk(jsld_pkg::CH_LF, jsld_pkg::ST_DATA);
               jsld_pkg::CH_LOW_R: push_cmd.slot[0] = mk(jsld_pkg::CH_CR, jsld_pkg::ST_DATA);
               jsld_pkg::CH_LOW_T: push_cmd.slot[0] = mk(jsld_pkg::CH_TAB, jsld_pkg::ST_DATA);
               jsld_pkg::CH_LOW_U: begin
                  if (eoi) begin
                     push_cmd.slot[0] = mk(8'h00, jsld_pkg::ST_SHORTU);
                     open = 1'b0;
                  end else begin
                     pn = 2'd0;
                  end
               end
               default: begin
                  push_cmd.slot[0] = mk(8'h00, jsld_pkg::ST_BADESC);
                  open = 1'b0;
               end
            endcase
         end
         jsld_pkg::PH_HEX: begin
            if (!hv_ok) begin
               push_cmd.slot[0] = mk(8'h00, jsld_pkg::ST_BADHEX);
               pn = 2'd1;
            end else if (cnt_ff == 2'd3) begin
               open = 1'b1;
               if (code_shift < jsld_pkg::UTF_LIM1) begin
                  push_cmd.slot[0] = mk(code_shift[7:0], jsld_pkg::ST_DATA);
                  pn = 2'd1;
               end else if (code_shift < jsld_pkg::UTF_LIM2) begin
                  push_cmd.slot[0] = mk(jsld_pkg::UTF_LEAD2 | {3'b000, code_shift[10:6]},
                                        jsld_pkg::ST_DATA);
                  push_cmd.slot[1] = mk(jsld_pkg::UTF_CONT | {2'b00, code_shift[5:0]},
                                        jsld_pkg::ST_DATA);
                  pn = 2'd2;
               end else begin
                  push_cmd.slot[0] = mk(jsld_pkg::UTF_LEAD3 | {4'h0, code_shift[15:12]},
                                        jsld_pkg::ST_DATA);
                  push_cmd.slot[1] = mk(jsld_pkg::UTF_CONT | {2'b00, code_shift[11:6]},
                                        jsld_pkg::ST_DATA);
                  push_cmd.slot[2] = mk(jsld_pkg::UTF_CONT | {2'b00, code_shift[5:0]},
                                        jsld_pkg::ST_DATA);
                  pn = 2'd3;
               end
            end else if (eoi) begin
               push_cmd.slot[0] = mk(8'h00, jsld_pkg::ST_SHORTU);
               pn = 2'd1;
            end else begin
               open = 1'b1;
            end
         end
         jsld_pkg::PH_SEEK: begin
            if (c == jsld_pkg::CH_QUOTE) begin
               open = 1'b1;
            end else if (!is_ws || eoi) begin
               push_cmd.slot[0] = mk(8'h00, jsld_pkg::ST_NOOPEN);
               pn = 2'd1;
            end
         end
      endcase
      if (eoi && open) begin
         push_cmd.slot[pn] = mk(8'h00, jsld_pkg::ST_UNTERM);
         push_cmd.count    = {1'b0, pn} + 3'd1;
      end else begin
         push_cmd.count = {1'b0, pn};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= jsld_pkg::PH_SEEK;
         code_ff  <= 16'h0000;
         cnt_ff   <= 2'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         code_ff  <= code_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/jsld_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module jsld_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire jsld_pkg::cmd_type push_cmd,
   input  wire logic              pop,
   output jsld_pkg::cmd_type      head_cmd,
   output jsld_pkg::qstat_type    qstat
);

   localparam int unsigned DEPTH = jsld_pkg::QUEUE_DEPTH;
   localparam int unsigned PW    = jsld_pkg::QPTR_WIDTH;

   jsld_pkg::cmd_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;

   assign wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign head_cmd         = mem_ff[rd_ptr_ff];
   assign qstat.head_valid = (count_ff != '0);
   assign qstat.full       = (count_ff == (PW+1)'(DEPTH));

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
      end
   end

endmodule

`default_nettype wire

>>> hdl/jsld_back.sv
`timescale 1ns / 1ps
`default_nettype none

module jsld_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire jsld_pkg::cmd_type   head_cmd,
   input  wire jsld_pkg::qstat_type qstat,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output jsld_pkg::rsp_type        rsp_data
);

   logic [1:0] idx_ff, idx_in;
   logic       is_last;

   assign is_last   = ({1'b0, idx_ff} + 3'd1) == head_cmd.count;
   assign rsp_valid = qstat.head_valid;
   assign pop       = rsp_valid && rsp_ready && is_last;

   assign rsp_data.out_byte = head_cmd.slot[idx_ff].out_byte;
   assign rsp_data.status   = head_cmd.slot[idx_ff].status;
   assign rsp_data.last     = is_last;

   always_comb begin
      idx_in = idx_ff;
      if (rsp_valid && rsp_ready) begin
         idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/json_string_literal_decoder_unit.sv
// An accepted byte's results are registered in the queue and reach rsp_ from its head.
// Throughput: one byte per cycle while each byte causes at most one result and rsp_ready
// stays high; a byte with several results needs one result transfer for each, and the
// two-entry queue between the scanner and the result sequencer absorbs the difference.
// Reset (synchronous, active high) returns the scanner to seeking an opening quote,
// clears the collected code point and digit count, and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module json_string_literal_decoder_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire jsld_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output jsld_pkg::rsp_type      rsp_data
);

   // The front part scans one byte per transfer and turns it into a command
   // that lists every result the byte causes, in order. Bytes that cause no
   // result (whitespace before the quote, a backslash, any but the last of the four
   // hex digits of a code point) leave no command behind.
   jsld_pkg::cmd_type   push_cmd;
   jsld_pkg::cmd_type   head_cmd;
   jsld_pkg::qstat_type qstat;
   logic                push;
   logic                pop;

   jsld_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .qstat     (qstat),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   // The queue decouples the two sides so that a stalled result channel
   // does not stop the scanner until both entries are taken.
   jsld_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .qstat    (qstat)
   );

   // The back part walks the results of the head command one per transfer
   // and marks the final one with last.
   jsld_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_cmd  (head_cmd),
      .qstat     (qstat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // A command in the queue always carries between one and four results.
   a_head_count: assert property (@(posedge clock) disable iff (reset)
      qstat.head_valid |-> (head_cmd.count != 3'd0) && (head_cmd.count <= 3'd4))
      else $error("queue head holds a command with an impossible result count");

   // The scanner never takes a byte while the queue has no room.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !req_ready)
      else $error("input accepted while the queue is full");

   // A command leaves the queue only on the transfer of its final result.
   a_pop_last: assert property (@(posedge clock) disable iff (reset)
      pop |-> rsp_valid && rsp_ready && rsp_data.last)
      else $error("command retired before its final result");

   // Only data results carry a byte value.
   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != jsld_pkg::ST_DATA) |-> rsp_data.out_byte == 8'h00)
      else $error("status result carries a nonzero byte");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

   // One row of stimulus. ntyped is PREDICTED when the expected results come from
   // the decoder model below. Otherwise it is the number of results typed into tres,
   // which is NO_RESULT or ONE_RESULT.
   typedef struct packed {
      jsld_pkg::req_type req;
      int                ntyped;
      jsld_pkg::rsp_type tres;
   } stim_item_type;

   localparam int PREDICTED  = -1;
   localparam int NO_RESULT  = 0;
   localparam int ONE_RESULT = 1;

   localparam int RANDOM_ITEMS = 200;
   localparam int DIR_ROWS     = 26;
   localparam int DRAIN_CYCLES = 10;
   // The receiver holds off once, after this many result transfers, for this long.
   localparam int HOLD_AFTER   = 60;
   localparam int HOLD_CYCLES  = 300;

   // Characters used by the hex digit decoder and the text generator.
   localparam logic [7:0] CH_ZERO  = "0";
   localparam logic [7:0] CH_NINE  = "9";
   localparam logic [7:0] CH_LOW_A = "a";
   localparam logic [7:0] CH_UP_A  = "A";
   localparam logic [7:0] CH_UP_F  = "F";

   localparam logic [7:0] ESC_LETTERS [8] = '{jsld_pkg::CH_QUOTE, jsld_pkg::CH_BSL,
                                              jsld_pkg::CH_SLASH, jsld_pkg::CH_LOW_B,
                                              jsld_pkg::CH_LOW_F, jsld_pkg::CH_LOW_N,
                                              jsld_pkg::CH_LOW_R, jsld_pkg::CH_LOW_T};
   localparam logic [7:0] BLANKS [4] = '{jsld_pkg::CH_SPACE, jsld_pkg::CH_TAB,
                                         jsld_pkg::CH_CR, jsld_pkg::CH_LF};

   // Results that can be read straight off the decoder's rules.
   localparam jsld_pkg::rsp_type R_NONE   = '0;
   localparam jsld_pkg::rsp_type R_NOOPEN =
      '{out_byte: 8'h00, status: jsld_pkg::ST_NOOPEN, last: 1'b1};
   localparam jsld_pkg::rsp_type R_UNTERM =
      '{out_byte: 8'h00, status: jsld_pkg::ST_UNTERM, last: 1'b1};
   localparam jsld_pkg::rsp_type R_CLOSED =
      '{out_byte: 8'h00, status: jsld_pkg::ST_CLOSED, last: 1'b1};
   localparam jsld_pkg::rsp_type R_BADHEX =
      '{out_byte: 8'h00, status: jsld_pkg::ST_BADHEX, last: 1'b1};
   localparam jsld_pkg::rsp_type R_BADESC =
      '{out_byte: 8'h00, status: jsld_pkg::ST_BADESC, last: 1'b1};
   localparam jsld_pkg::rsp_type R_SHORTU =
      '{out_byte: 8'h00, status: jsld_pkg::ST_SHORTU, last: 1'b1};
   localparam jsld_pkg::rsp_type R_DATAFF =
      '{out_byte: 8'hFF, status: jsld_pkg::ST_DATA, last: 1'b1};

   // Directed part. It starts right after reset, so the scanner is seeking a quote.
   localparam stim_item_type DIR_TBL [DIR_ROWS] = '{
      '{'{8'h00,              1'b0}, ONE_RESULT, R_NOOPEN},  // lowest byte for a quote
      '{'{jsld_pkg::CH_SPACE, 1'b0}, NO_RESULT,  R_NONE},    // whitespace is skipped
      '{'{jsld_pkg::CH_TAB,   1'b1}, ONE_RESULT, R_NOOPEN},  // whitespace ends the buffer
      '{'{jsld_pkg::CH_QUOTE, 1'b1}, ONE_RESULT, R_UNTERM},  // opening quote ends it
      '{'{jsld_pkg::CH_QUOTE, 1'b0}, NO_RESULT,  R_NONE},
      '{'{8'hFF,              1'b0}, ONE_RESULT, R_DATAFF},  // highest byte as data
      '{'{jsld_pkg::CH_BSL,   1'b0}, NO_RESULT,  R_NONE},
      '{'{jsld_pkg::CH_LOW_U, 1'b0}, PREDICTED,  R_NONE},
      '{'{CH_UP_F,            1'b0}, PREDICTED,  R_NONE},    // mixed case, top code point
      '{'{jsld_pkg::CH_LOW_F, 1'b0}, PREDICTED,  R_NONE},
      '{'{CH_UP_F,            1'b0}, PREDICTED,  R_NONE},
      '{'{jsld_pkg::CH_LOW_F, 1'b0}, PREDICTED,  R_NONE},    // three UTF-8 bytes here
      '{'{jsld_pkg::CH_QUOTE, 1'b0}, ONE_RESULT, R_CLOSED},
      '{'{jsld_pkg::CH_QUOTE, 1'b0}, PREDICTED,  R_NONE},
      '{'{jsld_pkg::CH_BSL,   1'b0}, PREDICTED,  R_NONE},
      '{'{jsld_pkg::CH_LOW_U, 1'b0}, PREDICTED,  R_NONE},
      '{'{CH_ZERO,            1'b0}, PREDICTED,  R_NONE},
      '{'{8'h67,              1'b0}, ONE_RESULT, R_BADHEX},  // 'g' is not a hex digit
      '{'{jsld_pkg::CH_QUOTE, 1'b0}, PREDICTED,  R_NONE},
      '{'{jsld_pkg::CH_BSL,   1'b0}, PREDICTED,  R_NONE},
      '{'{8'h71,              1'b0}, ONE_RESULT, R_BADESC},  // 'q' is no escape letter
      '{'{jsld_pkg::CH_QUOTE, 1'b0}, PREDICTED,  R_NONE},
      '{'{jsld_pkg::CH_BSL,   1'b1}, PREDICTED,  R_NONE},    // backslash ends the buffer
      '{'{jsld_pkg::CH_QUOTE, 1'b0}, PREDICTED,  R_NONE},
      '{'{jsld_pkg::CH_BSL,   1'b0}, PREDICTED,  R_NONE},
      '{'{jsld_pkg::CH_LOW_U, 1'b1}, ONE_RESULT, R_SHORTU}   // buffer ends right after \u
   };

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   jsld_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   jsld_pkg::rsp_type rsp_data;

   stim_item_type     stim_q[$];   // every byte of the run, directed rows first
   jsld_pkg::rsp_type expect_q[$]; // decoded results still owed by the block
   jsld_pkg::rsp_type decoded[$];  // results of the byte being decoded

   // Decoder model state, owned by the scoreboard process.
   jsld_pkg::phase_type scan_phase;
   logic [15:0]         code_acc;
   logic [2:0]          digit_cnt;

   int sent_cnt   = 0;  // transfers on the byte side, as seen by the sender
   int taken_cnt  = 0;  // the same, as seen by the scoreboard
   int rx_cnt     = 0;  // result transfers, as seen by the receiver
   int req_wait   = 0;
   int rsp_wait   = 0;
   int fail_cnt   = 0;
   int result_cnt = 0;
   int closed_cnt = 0;
   int error_cnt  = 0;

   json_string_literal_decoder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle gap between transfers: drawn at random, except in every third block of
   // 40 transfers, where both sides run back to back.
   function automatic int idle_draw(int n);
      if ((n / 40) % 3 == 1) return 0;
      return $urandom_range(0, 5);
   endfunction

   // Value of a hex digit in either case, or -1 when the byte is not one.
   function automatic int hex_nibble(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
      if (c >= CH_LOW_A && c <= jsld_pkg::CH_LOW_F) return int'(c - CH_LOW_A) + 10;
      if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
      return -1;
   endfunction

   // Hex digit for a nibble, letters in a random case.
   function automatic logic [7:0] hex_char(logic [3:0] v);
      if (v < 4'd10) return CH_ZERO + 8'(v);
      return ($urandom_range(0, 1) ? CH_LOW_A : CH_UP_A) + 8'(v) - 8'd10;
   endfunction

   function automatic void queue_byte(logic [7:0] b, logic eoi);
      stim_item_type item;
      item.req.in_byte      = b;
      item.req.end_of_input = eoi;
      item.ntyped           = PREDICTED;
      item.tres             = R_NONE;
      stim_q = {stim_q, item};
   endfunction

   function automatic void add_result(logic [7:0] b, jsld_pkg::status_type s);
      jsld_pkg::rsp_type r;
      r.out_byte = b;
      r.status   = s;
      r.last     = 1'b0;
      decoded = {decoded, r};
   endfunction

   // Decodes one raw byte: advances the model state and leaves the results of
   // this byte, in order, in decoded.
   function void decode_byte(jsld_pkg::req_type r);
      logic [7:0] c;
      logic       eoi;
      logic       str_open;
      int         nib;
      c        = r.in_byte;
      eoi      = r.end_of_input;
      str_open = 1'b0;
      decoded.delete();
      case (scan_phase)
         jsld_pkg::PH_BODY: begin
            if (c == jsld_pkg::CH_QUOTE) begin
               add_result(8'h00, jsld_pkg::ST_CLOSED);
               scan_phase = jsld_pkg::PH_SEEK;
            end else if (c == jsld_pkg::CH_BSL && !eoi) begin
               scan_phase = jsld_pkg::PH_ESC;
               str_open   = 1'b1;
            end else begin
               // A backslash that ends the buffer is kept as plain data.
               add_result(c, jsld_pkg::ST_DATA);
               str_open = 1'b1;
            end
         end
         jsld_pkg::PH_ESC: begin
            str_open   = 1'b1;
            scan_phase = jsld_pkg::PH_BODY;
            case (c)
               jsld_pkg::CH_QUOTE, jsld_pkg::CH_BSL, jsld_pkg::CH_SLASH:
                  add_result(c, jsld_pkg::ST_DATA);
               jsld_pkg::CH_LOW_B: add_result(jsld_pkg::CC_BS, jsld_pkg::ST_DATA);
               jsld_pkg::CH_LOW_F: add_result(jsld_pkg::CC_FF, jsld_pkg::ST_DATA);
               jsld_pkg::CH_LOW_N: add_result(jsld_pkg::CH_LF, jsld_pkg::ST_DATA);
               jsld_pkg::CH_LOW_R: add_result(jsld_pkg::CH_CR, jsld_pkg::ST_DATA);
               jsld_pkg::CH_LOW_T: add_result(jsld_pkg::CH_TAB, jsld_pkg::ST_DATA);
               jsld_pkg::CH_LOW_U: begin
                  if (eoi) begin
                     add_result(8'h00, jsld_pkg::ST_SHORTU);
                     str_open = 1'b0;
                  end else begin
                     scan_phase = jsld_pkg::PH_HEX;
                     code_acc   = '0;
                     digit_cnt  = '0;
                  end
               end
               default: begin
                  add_result(8'h00, jsld_pkg::ST_BADESC);
                  str_open   = 1'b0;
                  scan_phase = jsld_pkg::PH_SEEK;
               end
            endcase
         end
         jsld_pkg::PH_HEX: begin
            nib = hex_nibble(c);
            if (nib < 0) begin
               add_result(8'h00, jsld_pkg::ST_BADHEX);
               scan_phase = jsld_pkg::PH_SEEK;
            end else begin
               code_acc  = {code_acc[11:0], 4'(nib)};
               digit_cnt = digit_cnt + 3'd1;
               if (digit_cnt >= 3'd4) begin
                  // Four digits in: emit the code point as UTF-8, no surrogate pairing.
                  if (code_acc < jsld_pkg::UTF_LIM1) begin
                     add_result(code_acc[7:0], jsld_pkg::ST_DATA);
                  end else if (code_acc < jsld_pkg::UTF_LIM2) begin
                     add_result(jsld_pkg::UTF_LEAD2 | {3'b000, code_acc[10:6]},
                                jsld_pkg::ST_DATA);
                     add_result(jsld_pkg::UTF_CONT | {2'b00, code_acc[5:0]},
                                jsld_pkg::ST_DATA);
                  end else begin
                     add_result(jsld_pkg::UTF_LEAD3 | {4'b0000, code_acc[15:12]},
                                jsld_pkg::ST_DATA);
                     add_result(jsld_pkg::UTF_CONT | {2'b00, code_acc[11:6]},
                                jsld_pkg::ST_DATA);
                     add_result(jsld_pkg::UTF_CONT | {2'b00, code_acc[5:0]},
                                jsld_pkg::ST_DATA);
                  end
                  scan_phase = jsld_pkg::PH_BODY;
                  str_open   = 1'b1;
               end else if (eoi) begin
                  add_result(8'h00, jsld_pkg::ST_SHORTU);
               end else begin
                  str_open = 1'b1;
               end
            end
         end
         default: begin
            scan_phase = jsld_pkg::PH_SEEK;
            if (c == jsld_pkg::CH_QUOTE) begin
               scan_phase = jsld_pkg::PH_BODY;
               str_open   = 1'b1;
            end else if (c == jsld_pkg::CH_SPACE || c == jsld_pkg::CH_TAB ||
                         c == jsld_pkg::CH_CR || c == jsld_pkg::CH_LF) begin
               if (eoi) add_result(8'h00, jsld_pkg::ST_NOOPEN);
            end else begin
               add_result(8'h00, jsld_pkg::ST_NOOPEN);
            end
         end
      endcase
      // The end of the buffer closes whatever is still open and rearms the scanner.
      if (eoi) begin
         if (str_open) add_result(8'h00, jsld_pkg::ST_UNTERM);
         scan_phase = jsld_pkg::PH_SEEK;
         code_acc   = '0;
         digit_cnt  = '0;
      end
      if (decoded.size() != 0) decoded[decoded.size() - 1].last = 1'b1;
   endfunction

   // Sender. A byte is offered after its idle gap and held, unchanged, until the
   // transfer; the gap before the next byte is drawn when a byte goes up.
   always @(posedge clock) begin : sender
      int nxt;
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         sent_cnt  <= 0;
         req_wait  <= 0;
      end else if (!req_valid || req_ready) begin
         nxt = sent_cnt + (req_valid ? 1 : 0);
         sent_cnt <= nxt;
         if (req_wait > 0) begin
            req_wait  <= req_wait - 1;
            req_valid <= 1'b0;
         end else if (nxt < stim_q.size()) begin
            req_valid <= 1'b1;
            req_data  <= stim_q[nxt].req;
            req_wait  <= idle_draw(nxt);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver. After each result transfer it drops ready for a random number of
   // cycles. Once, it holds off for a long stretch while the sender keeps offering
   // bytes, so the block's queue fills and req_ready has to fall.
   always @(posedge clock) begin : receiver
      int pause;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait  <= 0;
         rx_cnt    <= 0;
      end else if (rsp_valid && rsp_ready) begin
         pause = (rx_cnt + 1 == HOLD_AFTER) ? HOLD_CYCLES : idle_draw(rx_cnt);
         rx_cnt    <= rx_cnt + 1;
         rsp_wait  <= pause;
         rsp_ready <= (pause == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait  <= rsp_wait - 1;
         rsp_ready <= (rsp_wait == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Scoreboard. Every byte transfer runs through the decoder model, and its
   // results join the back of expect_q; typed rows put their own result there
   // instead. Every result transfer is checked against the front. Byte
   // transfers are handled first, so a result that arrives in the same cycle
   // as its byte still finds its expectation.
   always @(posedge clock) begin : scoreboard
      stim_item_type     item;
      jsld_pkg::rsp_type want;
      if (reset) begin
         scan_phase = jsld_pkg::PH_SEEK;
         code_acc   = '0;
         digit_cnt  = '0;
         expect_q.delete();
         taken_cnt <= 0;
      end else begin
         if (req_valid && req_ready) begin
            item = stim_q[taken_cnt];
            decode_byte(item.req);
            if (item.ntyped == PREDICTED) begin
               expect_q = {expect_q, decoded};
            end else if (item.ntyped == ONE_RESULT) begin
               expect_q = {expect_q, item.tres};
            end
            taken_cnt <= taken_cnt + 1;
         end
         if (rsp_valid && rsp_ready) begin
            result_cnt++;
            if (expect_q.size() == 0) begin
               $error("unexpected result: out_byte %h status %0d last %0d",
                      rsp_data.out_byte, rsp_data.status, rsp_data.last);
               fail_cnt++;
            end else begin
               want = expect_q.pop_front();
               if (want.status == jsld_pkg::ST_CLOSED) closed_cnt++;
               if (want.status >= jsld_pkg::ST_NOOPEN) error_cnt++;
               if (rsp_data.out_byte !== want.out_byte) begin
                  $error("out_byte mismatch: expected %h, got %h",
                         want.out_byte, rsp_data.out_byte);
                  fail_cnt++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status mismatch: expected %0d, got %0d",
                         want.status, rsp_data.status);
                  fail_cnt++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last mismatch: expected %0d, got %0d", want.last, rsp_data.last);
                  fail_cnt++;
               end
            end
         end
      end
   end

   // Builds the stimulus, releases reset and waits for the run to drain.
   initial begin : main
      logic [7:0]  text[$];
      logic [7:0]  ch;
      logic [15:0] cp;
      int          eoi_at;
      int          kind;
      bit          is_esc;

      foreach (DIR_TBL[i]) stim_q = {stim_q, DIR_TBL[i]};

      // Random part: mostly well-formed strings with random content, some of them
      // cut short by the end of the buffer, plus broken escapes and stray bytes.
      while (stim_q.size() < DIR_ROWS + RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) begin
            // Stray bytes where a quote is expected; any of them may end the buffer.
            repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)),
                                                     $urandom_range(0, 3) == 0);
            continue;
         end
         text.delete();
         repeat ($urandom_range(0, 2)) text = {text, BLANKS[$urandom_range(0, 3)]};
         text = {text, jsld_pkg::CH_QUOTE};
         repeat ($urandom_range(0, 6)) begin
            kind = $urandom_range(0, 9);
            if (kind < 5) begin
               do ch = 8'($urandom_range(0, 255));
               while (ch == jsld_pkg::CH_QUOTE || ch == jsld_pkg::CH_BSL);
               text = {text, ch};
            end else if (kind < 7) begin
               text = {text, jsld_pkg::CH_BSL};
               text = {text, ESC_LETTERS[$urandom_range(0, 7)]};
            end else if (kind < 9) begin
               // One code point from a UTF-8 length class chosen evenly at random.
               case ($urandom_range(0, 2))
                  0:       cp = 16'($urandom_range(0, 'h7F));
                  1:       cp = 16'($urandom_range('h80, 'h7FF));
                  default: cp = 16'($urandom_range('h800, 'hFFFF));
               endcase
               text = {text, jsld_pkg::CH_BSL};
               text = {text, jsld_pkg::CH_LOW_U};
               for (int k = 3; k >= 0; k--) text = {text, hex_char(cp[k*4 +: 4])};
            end else if ($urandom_range(0, 1)) begin
               // Backslash followed by a byte that names no escape.
               do begin
                  ch     = 8'($urandom_range(0, 255));
                  is_esc = (ch == jsld_pkg::CH_LOW_U);
                  foreach (ESC_LETTERS[i]) if (ch == ESC_LETTERS[i]) is_esc = 1'b1;
               end while (is_esc);
               text = {text, jsld_pkg::CH_BSL};
               text = {text, ch};
            end else begin
               // A \u run broken by a non-hex byte after zero to three digits.
               text = {text, jsld_pkg::CH_BSL};
               text = {text, jsld_pkg::CH_LOW_U};
               repeat ($urandom_range(0, 3))
                  text = {text, hex_char(4'($urandom_range(0, 15)))};
               do ch = 8'($urandom_range(0, 255)); while (hex_nibble(ch) >= 0);
               text = {text, ch};
            end
         end
         text = {text, jsld_pkg::CH_QUOTE};
         // Where the buffer ends: usually not in this string, sometimes on the
         // closing quote, sometimes at a random byte that cuts the string short.
         case ($urandom_range(0, 9))
            0, 1:    eoi_at = $urandom_range(0, text.size() - 1);
            2:       eoi_at = text.size() - 1;
            default: eoi_at = text.size();
         endcase
         foreach (text[i]) if (i <= eoi_at) queue_byte(text[i], i == eoi_at);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (sent_cnt < stim_q.size() || expect_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d bytes (%0d directed, the rest random) and checked %0d results.",
               stim_q.size(), DIR_ROWS, result_cnt);
      $display("Seen: %0d closed strings, %0d error reports, one %0d-cycle receiver hold.",
               closed_cnt, error_cnt, HOLD_CYCLES);
      if (fail_cnt == 0 && expect_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog: a correct run takes well under a tenth of this.
   initial begin : watchdog
      #1ms;
      $display("Run did not finish in time.");
      $display("status: fail");
      $finish;
   end

endmodule
